### src/usbhpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the hub port-change sequencer.
// No dependencies.
package usbhpc_pkg;

   localparam int MAX_CHILDREN_DEF = 7;
   localparam int REQ_DATA_W       = 56;
   localparam int RSP_DATA_W       = 32;
   localparam int CSR_DATA_W       = 10;
   localparam int CSR_ADDR_W       = 2;
   localparam int QUEUE_DEPTH      = 2;

   typedef enum logic [1:0] {
      CSR_NUM_PORTS   = 2'd0,
      CSR_POWER_UNITS = 2'd1,
      CSR_HUB_DEPTH   = 2'd2,
      CSR_RESET_WAIT  = 2'd3
   } csr_addr_type;

   typedef enum logic [1:0] {
      KIND_BITMAP = 2'd0,
      KIND_XFER   = 2'd1,
      KIND_TIMER  = 2'd2,
      KIND_ENUM   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      CMD_GET_STATUS = 3'd0,
      CMD_CLEAR_FEAT = 3'd1,
      CMD_ARM_TIMER  = 3'd2,
      CMD_SET_RESET  = 3'd3,
      CMD_ENUMERATE  = 3'd4,
      CMD_POWER      = 3'd5,
      CMD_SCAN_DONE  = 3'd6,
      CMD_HALTED     = 3'd7
   } cmd_type;

   localparam logic [2:0] FEAT_CONNECT = 3'd0;
   localparam logic [2:0] FEAT_ENABLE  = 3'd1;
   localparam logic [2:0] FEAT_SUSPEND = 3'd2;
   localparam logic [2:0] FEAT_OVERCUR = 3'd3;
   localparam logic [2:0] FEAT_RESET   = 3'd4;

   localparam logic [1:0] PWR_ATTACH  = 2'd0;
   localparam logic [1:0] PWR_DETACH  = 2'd1;
   localparam logic [1:0] PWR_SUSPEND = 2'd2;
   localparam logic [1:0] PWR_RESUME  = 2'd3;

   typedef struct packed {
      logic [3:0] num_ports;
      logic [7:0] power_units;
      logic [2:0] hub_depth;
      logic [9:0] reset_first_wait;
   } cfg_type;

   typedef struct packed {
      req_kind_type kind;
      logic [15:0]  change_bitmap;
      logic         xfer_ok;
      logic [15:0]  port_status;
      logic [15:0]  port_change;
      logic         enum_ok;
   } req_item_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [3:0]  port;
      logic [2:0]  feature;
      logic [15:0] wait_ms;
      logic [1:0]  speed;
      logic [1:0]  power_code;
      logic [2:0]  child_slot;
      logic        last;
   } rsp_item_type;

endpackage

### src/usbhpc_front.sv
`timescale 1ns / 1ps
// Front end: takes request beats, tags them by kind and queues them.
// Depends on usbhpc_pkg.
module usbhpc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [1:0]                in_kind,
   input  logic [15:0]               in_bitmap,
   input  logic                      in_xfer_ok,
   input  logic [15:0]               in_status,
   input  logic [15:0]               in_change,
   input  logic                      in_enum_ok,
   output logic                      q_valid,
   input  logic                      q_pop,
   output usbhpc_pkg::req_item_type  q_item
);
   import usbhpc_pkg::*;

   req_item_type q_ff [QUEUE_DEPTH];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push;
   req_item_type item;

   always_comb begin
      // every 2-bit value is a defined kind
      item.kind          = req_kind_type'(in_kind);
      item.change_bitmap = in_bitmap;
      item.xfer_ok       = in_xfer_ok;
      item.port_status   = in_status;
      item.port_change   = in_change;
      item.enum_ok       = in_enum_ok;
   end

   assign in_ready  = (cnt_ff != 2'(QUEUE_DEPTH));
   assign push      = in_valid && in_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = q_ff[rd_ptr_ff];
   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end
endmodule

### src/usbhpc_engine.sv
`timescale 1ns / 1ps
// Back end: port-change state machine, runs one queued event and
// plays its commands out one beat at a time. Depends on usbhpc_pkg.
module usbhpc_engine #(
   parameter int MAX_CHILDREN = usbhpc_pkg::MAX_CHILDREN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  usbhpc_pkg::cfg_type       cfg,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  usbhpc_pkg::req_item_type  q_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output usbhpc_pkg::rsp_item_type  out_item
);
   import usbhpc_pkg::*;

   localparam int IDX_W = $clog2(MAX_CHILDREN + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_GOT_STATUS, ST_CONN_DONE, ST_EN_DONE, ST_SUSP_DONE, ST_RST_DONE,
      ST_OC, ST_OC_CONT, ST_OC_DONE, ST_DEB_WAIT, ST_DEB_STATUS, ST_RST_START,
      ST_RST_STATUS, ST_RST_COMPLETE, ST_DISCONNECT, ST_ENUM_WAIT
   } state_type;

   state_type    ps_ff, ps_in, ns_ff, ns_in;
   logic [3:0]   sp_ff, sp_in;
   logic [15:0]  pend_ff, pend_in, ss_ff, ss_in, sc_ff, sc_in;
   logic [15:0]  dw_ff, dw_in, rw_ff, rw_in;
   logic [2:0]   de_ff, de_in, rt_ff, rt_in;
   logic [1:0]   spd_ff, spd_in;
   logic [2:0]   cslot_ff, cslot_in;
   logic         cv_ff [MAX_CHILDREN];
   logic         cv_in [MAX_CHILDREN];
   logic [3:0]   cport_ff [MAX_CHILDREN];
   logic [3:0]   cport_in [MAX_CHILDREN];
   rsp_item_type res_ff [3];
   rsp_item_type res_in [3];
   logic [1:0]   cnt_in;
   logic [1:0]   rem_ff, rem_in;
   logic [1:0]   idx_ff, idx_in;

   function automatic logic halted(state_type s);
      return s == ST_OC || s == ST_OC_CONT || s == ST_DISCONNECT;
   endfunction

   function automatic logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] v;
      v = {1'b0, a} + {1'b0, b};
      return v[16] ? 16'hFFFF : v[15:0];
   endfunction

   function automatic rsp_item_type mk(cmd_type c, logic [3:0] p, logic [2:0] f,
                                       logic [15:0] w, logic [1:0] s,
                                       logic [1:0] pc, logic [2:0] sl);
      rsp_item_type r;
      r.cmd        = c;
      r.port       = (c == CMD_SCAN_DONE || c == CMD_HALTED) ? 4'd0 : p;
      r.feature    = f;
      r.wait_ms    = w;
      r.speed      = s;
      r.power_code = pc;
      r.child_slot = sl;
      r.last       = 1'b0;
      return r;
   endfunction

   // {hit, port}: first marked port from start up to num_ports
   function automatic logic [4:0] scan_find(logic [15:0] pend, logic [4:0] start,
                                            logic [3:0] np);
      logic       hit;
      logic [3:0] port;
      hit  = 1'b0;
      port = 4'd0;
      for (int p = 1; p < 16; p++) begin
         if (!hit && 5'(p) >= start && 4'(p) <= np && pend[p]) begin
            hit  = 1'b1;
            port = 4'(p);
         end
      end
      return {hit, port};
   endfunction

   assign q_pop     = q_valid && (rem_ff == 2'd0);
   assign out_valid = (rem_ff != 2'd0);
   assign out_item  = res_ff[idx_ff];

   always_comb begin
      logic            walk;
      state_type       ws;
      logic            scan_go;
      logic [4:0]      scan_st;
      logic [4:0]      found;
      logic            known;
      logic [IDX_W-1:0] free_slot;
      logic [15:0]     st;

      ps_in = ps_ff;  ns_in = ns_ff;  sp_in = sp_ff;  pend_in = pend_ff;
      ss_in = ss_ff;  sc_in = sc_ff;  dw_in = dw_ff;  rw_in = rw_ff;
      de_in = de_ff;  rt_in = rt_ff;  spd_in = spd_ff; cslot_in = cslot_ff;
      cv_in = cv_ff;  cport_in = cport_ff;
      res_in  = res_ff;
      cnt_in  = 2'd0;
      walk    = 1'b0;
      ws      = ST_IDLE;
      scan_go = 1'b0;
      scan_st = 5'd1;
      known   = 1'b0;
      free_slot = IDX_W'(MAX_CHILDREN);
      st      = q_item.port_status;
      found   = 5'd0;

      if (halted(ps_ff)) begin
         res_in[0] = mk(CMD_HALTED, sp_in, 3'd0, 16'd0, 2'd0, 2'd0, 3'd0);
         cnt_in    = 2'd1;
      end else begin
         case (q_item.kind)
            KIND_BITMAP: begin
               if (ns_ff == ST_IDLE) begin
                  pend_in = q_item.change_bitmap;
                  ps_in   = ST_IDLE;
                  scan_go = 1'b1;
                  scan_st = 5'd1;
               end
            end
            KIND_XFER: begin
               if (q_item.xfer_ok) begin
                  if (ns_ff == ST_DEB_WAIT || ns_ff == ST_DEB_STATUS) begin
                     ps_in = ns_ff;
                     walk  = 1'b0;
                     if (ns_ff == ST_DEB_STATUS && st[0] && dw_ff > 16'd200) begin
                        ns_in = ST_RST_START;
                        rw_in = {6'd0, cfg.reset_first_wait};
                        rt_in = 3'd0;
                        res_in[0] = mk(CMD_SET_RESET, sp_in, 3'd0, 16'd0, 2'd0, 2'd0,
                                       3'd0);
                        cnt_in = 2'd1;
                     end else begin
                        if (ns_ff == ST_DEB_STATUS && !st[0]) begin
                           dw_in = 16'd100;
                           if (de_ff < 3'd7) de_in = de_ff + 3'd1;
                           if (de_in > 3'd3) walk = 1'b1;
                        end
                        if (walk) begin
                           ns_in = ST_CONN_DONE;
                           ws    = ST_CONN_DONE;
                        end else begin
                           ns_in = ST_DEB_STATUS;
                           res_in[0] = mk(CMD_ARM_TIMER, sp_in, 3'd0, dw_in, 2'd0,
                                          2'd0, 3'd0);
                           cnt_in = 2'd1;
                        end
                     end
                  end else if (ns_ff == ST_RST_START || ns_ff == ST_RST_STATUS) begin
                     ps_in = ns_ff;
                     if (ns_ff == ST_RST_STATUS && (!st[0] || (!st[1] && rt_ff >= 3'd5)))
                     begin
                        walk  = 1'b1;
                        ns_in = ST_CONN_DONE;
                        ws    = ST_CONN_DONE;
                     end else if (ns_ff == ST_RST_STATUS && st[1]) begin
                        spd_in = st[9] ? 2'd1 : (st[10] ? 2'd3 : 2'd2);
                        ns_in  = ST_RST_COMPLETE;
                        res_in[0] = mk(CMD_CLEAR_FEAT, sp_in, FEAT_RESET, 16'd0, 2'd0,
                                       2'd0, 3'd0);
                        cnt_in = 2'd1;
                     end else begin
                        if (ns_ff == ST_RST_STATUS && rw_ff > 16'd100) begin
                           rt_in = rt_ff + 3'd1;
                           rw_in = 16'd10;
                        end
                        ns_in = ST_RST_STATUS;
                        res_in[0] = mk(CMD_ARM_TIMER, sp_in, 3'd0, rw_in, 2'd0, 2'd0,
                                       3'd0);
                        cnt_in = 2'd1;
                     end
                  end else if (ns_ff == ST_RST_COMPLETE) begin
                     ps_in = ST_RST_COMPLETE;
                     for (int i = 0; i < MAX_CHILDREN; i++) begin
                        if (!known) begin
                           if (cv_ff[i]) begin
                              if (cport_ff[i] == sp_ff) known = 1'b1;
                           end else if (free_slot == IDX_W'(MAX_CHILDREN)) begin
                              free_slot = IDX_W'(i);
                           end
                        end
                     end
                     walk = 1'b1;
                     if (!known && free_slot != IDX_W'(MAX_CHILDREN)) begin
                        cslot_in = 3'(free_slot);
                        if (cfg.hub_depth < 3'd6) begin
                           walk  = 1'b0;
                           ns_in = ST_ENUM_WAIT;
                           res_in[0] = mk(CMD_ENUMERATE, sp_in, 3'd0, 16'd0, spd_ff,
                                          2'd0, cslot_in);
                           cnt_in = 2'd1;
                        end
                     end
                     if (walk) begin
                        ns_in = ST_CONN_DONE;
                        ws    = ST_CONN_DONE;
                     end
                  end else if (ns_ff != ST_IDLE && ns_ff != ST_OC_CONT &&
                               ns_ff != ST_ENUM_WAIT) begin
                     walk = 1'b1;
                     ws   = ns_ff;
                  end
               end
            end
            KIND_TIMER: begin
               if (ns_ff == ST_DEB_STATUS) begin
                  dw_in = sat_add(dw_ff, 16'd50);
                  res_in[0] = mk(CMD_GET_STATUS, sp_in, 3'd0, 16'd0, 2'd0, 2'd0, 3'd0);
                  cnt_in = 2'd1;
               end else if (ns_ff == ST_RST_STATUS) begin
                  rw_in = sat_add(rw_ff, 16'd20);
                  res_in[0] = mk(CMD_GET_STATUS, sp_in, 3'd0, 16'd0, 2'd0, 2'd0, 3'd0);
                  cnt_in = 2'd1;
               end
            end
            default: begin
               if (ns_ff == ST_ENUM_WAIT) begin
                  if (q_item.enum_ok && int'(cslot_ff) < MAX_CHILDREN) begin
                     res_in[0] = mk(CMD_POWER, sp_in, 3'd0, 16'd0, 2'd0, PWR_ATTACH,
                                    3'd0);
                     cnt_in = 2'd1;
                     for (int i = 0; i < MAX_CHILDREN; i++) begin
                        if (int'(cslot_ff) == i) begin
                           cv_in[i]    = 1'b1;
                           cport_in[i] = sp_ff;
                        end
                     end
                  end
                  walk  = 1'b1;
                  ns_in = ST_CONN_DONE;
                  ws    = ST_CONN_DONE;
               end
            end
         endcase
      end

      // status walk: clear each set change feature in order
      for (int k = 0; k < 7; k++) begin
         if (walk) begin
            ps_in = ws;
            walk  = 1'b0;
            case (ws)
               ST_GOT_STATUS: begin
                  ss_in = q_item.port_status;
                  sc_in = q_item.port_change;
                  if (!sc_in[0]) begin
                     ws = ST_CONN_DONE; walk = 1'b1;
                  end else if (ss_in[0]) begin
                     dw_in = 16'd100;
                     de_in = 3'd0;
                     ns_in = (cfg.power_units < 8'd5) ? ST_DEB_WAIT : ST_CONN_DONE;
                     res_in[cnt_in] = mk(CMD_CLEAR_FEAT, sp_in, FEAT_CONNECT, 16'd0,
                                         2'd0, 2'd0, 3'd0);
                     cnt_in = cnt_in + 2'd1;
                  end else begin
                     ns_in = ST_DISCONNECT;
                     res_in[cnt_in] = mk(CMD_POWER, sp_in, 3'd0, 16'd0, 2'd0,
                                         PWR_DETACH, 3'd0);
                     res_in[cnt_in + 2'd1] = mk(CMD_CLEAR_FEAT, sp_in, FEAT_CONNECT,
                                                16'd0, 2'd0, 2'd0, 3'd0);
                     cnt_in = cnt_in + 2'd2;
                  end
               end
               ST_CONN_DONE: begin
                  if (!sc_in[1]) begin
                     ws = ST_EN_DONE; walk = 1'b1;
                  end else begin
                     ns_in = ST_EN_DONE;
                     res_in[cnt_in] = mk(CMD_CLEAR_FEAT, sp_in, FEAT_ENABLE, 16'd0,
                                         2'd0, 2'd0, 3'd0);
                     cnt_in = cnt_in + 2'd1;
                  end
               end
               ST_EN_DONE: begin
                  if (!sc_in[2]) begin
                     ws = ST_SUSP_DONE; walk = 1'b1;
                  end else begin
                     ns_in = ST_SUSP_DONE;
                     res_in[cnt_in] = mk(CMD_POWER, sp_in, 3'd0, 16'd0, 2'd0,
                                         ss_in[2] ? PWR_SUSPEND : PWR_RESUME, 3'd0);
                     res_in[cnt_in + 2'd1] = mk(CMD_CLEAR_FEAT, sp_in, FEAT_SUSPEND,
                                                16'd0, 2'd0, 2'd0, 3'd0);
                     cnt_in = cnt_in + 2'd2;
                  end
               end
               ST_SUSP_DONE: begin
                  if (!sc_in[3]) begin
                     ws = ST_OC_DONE; walk = 1'b1;
                  end else begin
                     ns_in = ss_in[3] ? ST_OC : ST_OC_DONE;
                     res_in[cnt_in] = mk(CMD_CLEAR_FEAT, sp_in, FEAT_OVERCUR, 16'd0,
                                         2'd0, 2'd0, 3'd0);
                     cnt_in = cnt_in + 2'd1;
                  end
               end
               ST_OC_DONE: begin
                  if (!sc_in[4]) begin
                     ws = ST_RST_DONE; walk = 1'b1;
                  end else begin
                     ns_in = ST_RST_DONE;
                     res_in[cnt_in] = mk(CMD_CLEAR_FEAT, sp_in, FEAT_RESET, 16'd0,
                                         2'd0, 2'd0, 3'd0);
                     cnt_in = cnt_in + 2'd1;
                  end
               end
               ST_RST_DONE: begin
                  ps_in   = ST_IDLE;
                  ns_in   = ST_IDLE;
                  scan_go = 1'b1;
                  scan_st = {1'b0, sp_in} + 5'd1;
               end
               default: begin
                  if (halted(ws)) begin
                     res_in[cnt_in] = mk(CMD_HALTED, sp_in, 3'd0, 16'd0, 2'd0, 2'd0,
                                         3'd0);
                     cnt_in = cnt_in + 2'd1;
                  end
               end
            endcase
         end
      end

      if (scan_go) begin
         found = scan_find(pend_in, scan_st, cfg.num_ports);
         if (found[4]) begin
            sp_in = found[3:0];
            ns_in = ST_GOT_STATUS;
            res_in[cnt_in] = mk(CMD_GET_STATUS, sp_in, 3'd0, 16'd0, 2'd0, 2'd0, 3'd0);
         end else begin
            sp_in = 4'd1;
            res_in[cnt_in] = mk(CMD_SCAN_DONE, sp_in, 3'd0, 16'd0, 2'd0, 2'd0, 3'd0);
         end
         cnt_in = cnt_in + 2'd1;
      end

      if (cnt_in != 2'd0) res_in[cnt_in - 2'd1].last = 1'b1;

      if (q_pop) begin
         rem_in = cnt_in;
         idx_in = 2'd0;
      end else begin
         rem_in = rem_ff;
         idx_in = idx_ff;
         if (out_valid && out_ready) begin
            rem_in = rem_ff - 2'd1;
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff <= ST_IDLE;  ns_ff <= ST_IDLE;  sp_ff <= 4'd1;
         pend_ff <= '0;  ss_ff <= '0;  sc_ff <= '0;  dw_ff <= '0;  rw_ff <= '0;
         de_ff <= '0;  rt_ff <= '0;  spd_ff <= '0;  cslot_ff <= '0;
         for (int i = 0; i < MAX_CHILDREN; i++) begin
            cv_ff[i]    <= 1'b0;
            cport_ff[i] <= 4'd0;
         end
         rem_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else begin
         if (q_pop) begin
            ps_ff <= ps_in;  ns_ff <= ns_in;  sp_ff <= sp_in;  pend_ff <= pend_in;
            ss_ff <= ss_in;  sc_ff <= sc_in;  dw_ff <= dw_in;  rw_ff <= rw_in;
            de_ff <= de_in;  rt_ff <= rt_in;  spd_ff <= spd_in; cslot_ff <= cslot_in;
            cv_ff <= cv_in;  cport_ff <= cport_in;
            res_ff <= res_in;
         end
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end
endmodule

### src/usb_hub_port_change_sequencer_top.sv
`timescale 1ns / 1ps
// USB hub port-change sequencer: events go in, hub commands come out, one to three
// command beats per event (tlast on the final one), none for ignored events. An event
// is queued in a two-entry front queue; the back end pops it, runs it and plays its command
// beats out one at a time, taking no new event until every beat of the last one is taken.
// Depends on usbhpc_pkg, usbhpc_front, usbhpc_engine.
module usb_hub_port_change_sequencer_top #(
   parameter int MAX_CHILDREN = usbhpc_pkg::MAX_CHILDREN_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [usbhpc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [usbhpc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // change_bitmap[15:0], xfer_ok[16], port_status[32:17], port_change[48:33],
   // enum_ok[49]
   input  logic [usbhpc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type[1:0]
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // port[3:0], feature[6:4], wait_ms[22:7], speed[24:23], power_code[26:25],
   // child_slot[29:27]
   output logic [usbhpc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // cmd[2:0]
   output logic [2:0]                            rsp_tuser,
   output logic                                  rsp_tlast
);
   import usbhpc_pkg::*;

   cfg_type      cfg_ff;
   req_item_type q_item;
   rsp_item_type out_item;
   logic         q_valid, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_ports        <= 4'd4;
         cfg_ff.power_units      <= 8'd0;
         cfg_ff.hub_depth        <= 3'd0;
         cfg_ff.reset_first_wait <= 10'd10;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_NUM_PORTS:   cfg_ff.num_ports        <= csr_wdata[3:0];
            CSR_POWER_UNITS: cfg_ff.power_units      <= csr_wdata[7:0];
            CSR_HUB_DEPTH:   cfg_ff.hub_depth        <= csr_wdata[2:0];
            CSR_RESET_WAIT:  cfg_ff.reset_first_wait <= csr_wdata;
            default: ;
         endcase
      end
   end

   usbhpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_kind    (req_tuser),
      .in_bitmap  (req_tdata[15:0]),
      .in_xfer_ok (req_tdata[16]),
      .in_status  (req_tdata[32:17]),
      .in_change  (req_tdata[48:33]),
      .in_enum_ok (req_tdata[49]),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item)
   );

   usbhpc_engine #(.MAX_CHILDREN(MAX_CHILDREN)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tuser = out_item.cmd;
   assign rsp_tlast = out_item.last;
   assign rsp_tdata = {2'b00, out_item.child_slot, out_item.power_code, out_item.speed,
                       out_item.wait_ms, out_item.feature, out_item.port};
endmodule

### src/usbhpc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sequencer top, bound onto it below.
// Depends on usbhpc_pkg and usb_hub_port_change_sequencer_top.
module usbhpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import usbhpc_pkg::*;

   // halted and scan-done beats carry no port
   a_no_port: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CMD_HALTED || rsp_tuser == CMD_SCAN_DONE)
      |-> rsp_tdata[3:0] == 4'd0)
      else $error("port set on halted or scan done beat");

   a_feat_only_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != CMD_CLEAR_FEAT |-> rsp_tdata[6:4] == 3'd0)
      else $error("feature set outside clear feature");

   a_halt_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == CMD_HALTED |-> rsp_tlast)
      else $error("halted beat not last");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled beat changed");
endmodule

bind usb_hub_port_change_sequencer_top usbhpc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
